FILE: rtl/asc_pkg.sv
// Shared types, widths and helper functions for the box sweep clamp block.
package asc_pkg;

	localparam int COORD_W = 32;
	localparam int DIM_W = 31;
	localparam int VEL_W = 32;
	localparam int EL_W = 16;
	localparam int EL_FRAC = 16;
	localparam int IDX_W = 6;
	localparam int WIDE_W = 36;
	localparam int PROD_W = VEL_W + EL_W + 1;
	localparam int DATA_IN_W = 184;

	// Request kinds carried on s_tuser.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_MOVE = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [DIM_W-1:0] dim_t;

	localparam wide_t COORD_MAX = 36'sh0_7FFF_FFFF;
	localparam wide_t COORD_MIN = 36'shF_8000_0000;

	// Request token that travels down the cell row. Edges of the mover are
	// precomputed once so that each cell only adds delta, compares and takes one difference.
	typedef struct packed {
		logic   valid;
		logic   done;
		logic   axis;
		coord_t delta;
		wide_t  m0;
		wide_t  mfar;
		wide_t  mfar_p1;
		wide_t  m0_m1;
		wide_t  c0;
		wide_t  c1;
	} tok_t;

	// Obstacle data broadcast to all cells on a load request.
	typedef struct packed {
		coord_t left;
		coord_t top;
		wide_t  far_x;
		wide_t  far_y;
		logic   solid;
	} load_t;

	function automatic wide_t wext(input coord_t v);
		return wide_t'(v);
	endfunction

	function automatic wide_t dext(input dim_t v);
		return wide_t'({1'b0, v});
	endfunction

	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/asc_head.sv
// Front stage: velocity times elapsed product and mover edge precompute.
module asc_head (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               start,
	input  asc_pkg::coord_t    box_left,
	input  asc_pkg::coord_t    box_top,
	input  asc_pkg::dim_t      box_width,
	input  asc_pkg::dim_t      box_height,
	input  logic               axis,
	input  asc_pkg::coord_t    velocity,
	input  logic [asc_pkg::EL_W-1:0] elapsed,
	output asc_pkg::tok_t      tok
);
	import asc_pkg::*;

	logic                     valid_s1;
	logic                     axis_s1;
	logic signed [PROD_W-1:0] prod_s1;
	wide_t                    m0_s1, mfar_s1, c0_s1, c1_s1;
	wide_t                    near_a, far_a, near_c, far_c;
	coord_t                   delta;

	always_comb begin
		near_a = axis ? wext(box_top) : wext(box_left);
		far_a  = axis ? (wext(box_top) + dext(box_height)) : (wext(box_left) + dext(box_width));
		near_c = axis ? wext(box_left) : wext(box_top);
		far_c  = axis ? (wext(box_left) + dext(box_width)) : (wext(box_top) + dext(box_height));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (start) begin
			valid_s1 <= 1'b1;
		end else if (en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			axis_s1 <= axis;
			prod_s1 <= $signed(velocity) * $signed({1'b0, elapsed});
			m0_s1   <= near_a;
			mfar_s1 <= far_a;
			c0_s1   <= near_c;
			c1_s1   <= far_c;
		end
	end

	// The floor shift of the product always fits the coordinate range.
	assign delta = prod_s1[EL_FRAC+COORD_W-1:EL_FRAC];

	always_comb begin
		tok.valid   = valid_s1;
		tok.done    = (delta == '0);
		tok.axis    = axis_s1;
		tok.delta   = delta;
		tok.m0      = m0_s1;
		tok.mfar    = mfar_s1;
		tok.mfar_p1 = mfar_s1 + wide_t'(1);
		tok.m0_m1   = m0_s1 - wide_t'(1);
		tok.c0      = c0_s1;
		tok.c1      = c1_s1;
	end

endmodule

FILE: rtl/asc_cell.sv
// One obstacle cell: holds an entry and clamps the passing request token.
module asc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           we,
	input  asc_pkg::load_t ld,
	input  asc_pkg::tok_t  tok_in,
	output asc_pkg::tok_t  tok_out
);
	import asc_pkg::*;

	logic   fixed_q;
	coord_t left_q, top_q;
	wide_t  far_x_q, far_y_q;
	wide_t  on, of, cn, cf, a0, a1;
	logic   hit;
	coord_t new_delta;
	tok_t   nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= 1'b0;
		end else if (we) begin
			fixed_q <= ld.solid;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			left_q  <= ld.left;
			top_q   <= ld.top;
			far_x_q <= ld.far_x;
			far_y_q <= ld.far_y;
		end
	end

	always_comb begin
		on = tok_in.axis ? wext(top_q) : wext(left_q);
		of = tok_in.axis ? far_y_q : far_x_q;
		cn = tok_in.axis ? wext(left_q) : wext(top_q);
		cf = tok_in.axis ? far_x_q : far_y_q;
		a0 = tok_in.m0 + wext(tok_in.delta);
		a1 = tok_in.mfar + wext(tok_in.delta);
		hit = fixed_q && !tok_in.done && (a0 < of) && (on < a1) &&
		      (tok_in.c0 < cf) && (cn < tok_in.c1);
		// Stop one LSB short of the near edge, or just past the far edge.
		if (tok_in.delta > 0) begin
			new_delta = sat_coord(on - tok_in.mfar_p1);
		end else begin
			new_delta = sat_coord(of - tok_in.m0_m1);
		end
		nxt = tok_in;
		if (hit) begin
			nxt.delta = new_delta;
			nxt.done  = (new_delta == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= nxt;
		end
	end

endmodule

FILE: rtl/aabb_sweep_clamp_core.sv
// Top level of the box sweep clamp block: input decode, cell row, result register.
// A load request writes one obstacle cell; s_tready stays high for it. A move
// request passes the velocity by elapsed product register, one register in each
// cell of the obstacle row, and the result register before its result appears;
// the row stalls while a finished move waits behind a result not yet taken.
// s_tready is low while a move is in flight, so the block takes no new request
// until that move has left the cell row, while a finished result may still
// wait on m_tready. Cells with a clear fixed flag, and all cells after the delta
// has reached zero, pass the move through unchanged.
module aabb_sweep_clamp_core #(
	parameter int MAX_OBSTACLES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index, box_left, box_top, box_width, box_height, entry_solid, axis,
	// velocity, elapsed, two zero pad bits
	input  logic [asc_pkg::DATA_IN_W-1:0]  s_tdata,
	// kind
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// applied_delta
	output logic [asc_pkg::COORD_W-1:0]    m_tdata,
	// moved
	output logic                           m_tuser
);
	import asc_pkg::*;

	logic [IDX_W-1:0] entry_index;
	coord_t           box_left, box_top, velocity;
	dim_t             box_width, box_height;
	logic             entry_solid, axis;
	logic [EL_W-1:0]  elapsed;
	logic             in_acc, start, load_ok, en, in_flight_q;
	load_t            ld;
	tok_t             tok [0:MAX_OBSTACLES];

	assign entry_index = s_tdata[5:0];
	assign box_left    = s_tdata[37:6];
	assign box_top     = s_tdata[69:38];
	assign box_width   = s_tdata[100:70];
	assign box_height  = s_tdata[131:101];
	assign entry_solid = s_tdata[132];
	assign axis        = s_tdata[133];
	assign velocity    = s_tdata[165:134];
	assign elapsed     = s_tdata[181:166];

	assign s_tready = !in_flight_q;
	assign in_acc   = s_tvalid && s_tready;
	assign start    = in_acc && (s_tuser == KIND_MOVE);
	assign load_ok  = in_acc && (s_tuser == KIND_LOAD) &&
	                  (32'(entry_index) < 32'(MAX_OBSTACLES));

	// The row advances unless a finished move is stuck behind a full result.
	assign en = !(tok[MAX_OBSTACLES].valid && m_tvalid && !m_tready);

	always_comb begin
		ld.left  = box_left;
		ld.top   = box_top;
		ld.far_x = wext(box_left) + dext(box_width);
		ld.far_y = wext(box_top) + dext(box_height);
		ld.solid = entry_solid;
	end

	asc_head u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.start     (start),
		.box_left  (box_left),
		.box_top   (box_top),
		.box_width (box_width),
		.box_height(box_height),
		.axis      (axis),
		.velocity  (velocity),
		.elapsed   (elapsed),
		.tok       (tok[0])
	);

	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		asc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.we     (load_ok && (32'(entry_index) == 32'(i))),
			.ld     (ld),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= 1'b0;
		end else if (start) begin
			in_flight_q <= 1'b1;
		end else if (tok[MAX_OBSTACLES].valid && en) begin
			in_flight_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (tok[MAX_OBSTACLES].valid && en) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_OBSTACLES].valid && en) begin
			m_tdata <= tok[MAX_OBSTACLES].delta;
			m_tuser <= (tok[MAX_OBSTACLES].delta != '0);
		end
	end

	a_moved_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata != '0)))
		else $error("moved flag disagrees with applied delta");

	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("input accepted while a move is in flight");

	a_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		(tok[MAX_OBSTACLES].valid && !en) |=> tok[MAX_OBSTACLES].valid)
		else $error("stalled move lost at end of cell row");

	a_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !tok[MAX_OBSTACLES].valid)
		else $error("request token present while input is ready");

endmodule

FILE: dv/aabb_sweep_clamp_core_tb.sv
// Self-checking testbench for the box sweep clamp block: obstacle loads and swept moves.
`timescale 1ns / 1ps

module aabb_sweep_clamp_core_tb;
	import asc_pkg::*;

	localparam int MAX_OBS = 64;
	localparam int UNIT = 65536;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = MAX_OBS + 20;
	localparam int HOLD_CYCLES = 600;

	localparam bit AXIS_X = 1'b0;
	localparam bit AXIS_Y = 1'b1;

	typedef struct packed {
		bit                kind;
		logic [IDX_W-1:0]  idx;
		coord_t            left;
		coord_t            top;
		dim_t              w;
		dim_t              h;
		logic              solid;
		logic              axis;
		coord_t            vel;
		logic [EL_W-1:0]   el;
	} sweep_req_t;

	typedef struct packed {
		coord_t delta;
		logic   moved;
	} sweep_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_IN_W-1:0]   s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [COORD_W-1:0]     m_tdata;
	logic                   m_tuser;

	// Predictor copy of the obstacle table.
	coord_t obs_left [MAX_OBS];
	coord_t obs_top [MAX_OBS];
	dim_t   obs_w [MAX_OBS];
	dim_t   obs_h [MAX_OBS];
	bit     obs_fixed [MAX_OBS];

	sweep_result_t expected_moves[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit long_hold = 1'b0;
	int stall_count = 0;
	int cycle_count = 0;
	int n_errors = 0;
	int n_loads = 0;
	int n_moves = 0;
	int n_clamped = 0;
	int n_still = 0;

	aabb_sweep_clamp_core #(
		.MAX_OBSTACLES(MAX_OBS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic coord_t clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return coord_t'(32'h7FFF_FFFF);
		end
		if (v < -64'sd2147483648) begin
			return coord_t'(32'h8000_0000);
		end
		return coord_t'(v);
	endfunction

	function automatic bit spans_cross(input longint a0, input longint alen,
			input longint b0, input longint blen);
		return (a0 < b0 + blen) && (b0 < a0 + alen);
	endfunction

	// Walks the table in slot order and clamps the swept delta against each fixed box.
	function automatic sweep_result_t predict_sweep(input sweep_req_t r, output bit clamped);
		sweep_result_t res;
		longint d, mx, my, m0, mlen, o0, olen, w, h, left, top;
		clamped = 1'b0;
		left = longint'(r.left);
		top = longint'(r.top);
		w = longint'(r.w);
		h = longint'(r.h);
		d = longint'(clip32((longint'(r.vel) * longint'(r.el)) >>> EL_FRAC));
		for (int i = 0; i < MAX_OBS; i++) begin
			if (d == 0) begin
				break;
			end
			if (!obs_fixed[i]) begin
				continue;
			end
			mx = (r.axis == AXIS_Y) ? left : left + d;
			my = (r.axis == AXIS_Y) ? top + d : top;
			if (spans_cross(mx, w, longint'(obs_left[i]), longint'(obs_w[i])) &&
					spans_cross(my, h, longint'(obs_top[i]), longint'(obs_h[i]))) begin
				m0 = (r.axis == AXIS_Y) ? top : left;
				mlen = (r.axis == AXIS_Y) ? h : w;
				o0 = (r.axis == AXIS_Y) ? longint'(obs_top[i]) : longint'(obs_left[i]);
				olen = (r.axis == AXIS_Y) ? longint'(obs_h[i]) : longint'(obs_w[i]);
				if (d > 0) begin
					d = longint'(clip32(o0 - m0 - mlen - 1));
				end else begin
					d = longint'(clip32(o0 - m0 + olen + 1));
				end
				clamped = 1'b1;
			end
		end
		res.delta = coord_t'(d);
		res.moved = (d != 0);
		return res;
	endfunction

	function automatic sweep_req_t load_req(input int slot, input coord_t left,
			input coord_t top, input int w, input int h, input bit solid);
		sweep_req_t r;
		r = '0;
		r.kind = KIND_LOAD;
		r.idx = slot[IDX_W-1:0];
		r.left = left;
		r.top = top;
		r.w = dim_t'(w);
		r.h = dim_t'(h);
		r.solid = solid;
		return r;
	endfunction

	function automatic sweep_req_t move_req(input coord_t left, input coord_t top,
			input int w, input int h, input bit ax, input coord_t vel,
			input logic [EL_W-1:0] el);
		sweep_req_t r;
		r = '0;
		r.kind = KIND_MOVE;
		r.left = left;
		r.top = top;
		r.w = dim_t'(w);
		r.h = dim_t'(h);
		r.axis = ax;
		r.vel = vel;
		r.el = el;
		return r;
	endfunction

	function automatic coord_t near_coord();
		return coord_t'($urandom_range(0, 32'h0100_0000)) - coord_t'(32'h0080_0000);
	endfunction

	// Mostly small scenes around the origin so that moves hit obstacles; a tenth is
	// full-range noise so that every field bit toggles.
	function automatic sweep_req_t random_request();
		sweep_req_t r;
		bit noise;
		noise = ($urandom_range(99) < 10);
		r.kind = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_MOVE;
		r.idx = IDX_W'($urandom);
		r.solid = ($urandom_range(99) < 75);
		r.axis = 1'($urandom_range(1));
		r.el = EL_W'($urandom);
		if (noise) begin
			r.left = coord_t'($urandom);
			r.top = coord_t'($urandom);
			r.w = dim_t'($urandom);
			r.h = dim_t'($urandom);
			r.vel = coord_t'($urandom);
		end else begin
			r.left = near_coord();
			r.top = near_coord();
			r.w = dim_t'($urandom_range(0, 24 * UNIT));
			r.h = dim_t'($urandom_range(0, 24 * UNIT));
			r.vel = near_coord();
			if ($urandom_range(99) < 3) begin
				r.vel = '0;
			end
		end
		return r;
	endfunction

	task automatic accept_request(input sweep_req_t r);
		sweep_result_t res;
		bit clamped;
		if (r.kind == KIND_LOAD) begin
			obs_left[r.idx] = r.left;
			obs_top[r.idx] = r.top;
			obs_w[r.idx] = r.w;
			obs_h[r.idx] = r.h;
			obs_fixed[r.idx] = r.solid;
			n_loads++;
		end else begin
			res = predict_sweep(r, clamped);
			expected_moves.push_back(res);
			n_moves++;
			if (clamped) begin
				n_clamped++;
			end
			if (!res.moved) begin
				n_still++;
			end
		end
	endtask

	// Offers one request and returns at the edge where it is taken.
	task automatic send_request(input sweep_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {2'b00, r.el, r.vel, r.axis, r.solid, r.h, r.w, r.top, r.left, r.idx};
		s_tuser <= r.kind;
		s_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_tready);
		accept_request(r);
	endtask

	task automatic test_product_rounding();
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, '0, 16'hFFFF));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, 5 * UNIT, '0));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, -1, 16'h0001));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_Y, -1, 16'hFFFF));
		send_request(move_req(coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF), '0,
			32'h7FFF_FFFF, AXIS_X, coord_t'(32'h8000_0000), 16'hFFFF));
		send_request(move_req(coord_t'(32'h7FFF_FFFF), coord_t'(32'h8000_0000),
			32'h7FFF_FFFF, '0, AXIS_Y, coord_t'(32'h7FFF_FFFF), 16'hFFFF));
	endtask

	task automatic test_clamp_x_axis();
		send_request(load_req(0, 10 * UNIT, '0, 4 * UNIT, 4 * UNIT, 1'b1));
		send_request(load_req(5, -12 * UNIT, '0, 4 * UNIT, 4 * UNIT, 1'b1));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, 20 * UNIT, 16'h8000));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, -20 * UNIT, 16'h8000));
	endtask

	task automatic test_clamp_y_axis();
		send_request(load_req(63, '0, 6 * UNIT, 2 * UNIT, UNIT, 1'b1));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_Y, 8 * UNIT, 16'hFFFF));
		// Clear of the obstacle in x, so the full delta goes through.
		send_request(move_req(5 * UNIT, '0, 2 * UNIT, 2 * UNIT, AXIS_Y, 8 * UNIT, 16'hFFFF));
	endtask

	task automatic test_walk_rules();
		// A box without the fixed flag sits in the path and must be ignored.
		send_request(load_req(1, 3 * UNIT, '0, UNIT, 4 * UNIT, 1'b0));
		send_request(move_req('0, '0, 2 * UNIT, 2 * UNIT, AXIS_X, 20 * UNIT, 16'h8000));
		// Mover already inside an obstacle: the clamp turns the delta around.
		send_request(move_req(9 * UNIT, '0, 2 * UNIT, 2 * UNIT, AXIS_X, 2 * UNIT, 16'h8000));
		// Far edge one LSB short of the obstacle: delta clamps to zero and the walk stops.
		send_request(move_req(7 * UNIT, '0, 3 * UNIT - 1, 2 * UNIT, AXIS_X, 2 * UNIT,
			16'h8000));
	endtask

	task automatic test_clamp_saturation();
		send_request(load_req(0, coord_t'(32'h8000_0000), coord_t'(32'h7FFF_FFFF),
			32'h7FFF_FFFF, '0, 1'b0));
		send_request(load_req(5, '0, '0, '0, 32'h7FFF_FFFF, 1'b0));
		send_request(load_req(63, '0, '0, '0, '0, 1'b0));
		send_request(load_req(2, coord_t'(32'hC000_0000), '0, 32'h7FFF_FFFF,
			2 * UNIT, 1'b1));
		send_request(move_req('0, '0, 32'h7FFF_FFFF, 2 * UNIT, AXIS_X, UNIT,
			16'hFFFF));
		send_request(load_req(2, coord_t'(32'h4000_0000), '0, 32'h7FFF_FFFF,
			2 * UNIT, 1'b1));
		send_request(move_req('0, '0, 32'h7FFF_FFFF, 2 * UNIT, AXIS_X, -UNIT,
			16'hFFFF));
	endtask

	task automatic test_random_scenes(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count) begin
			send_request(random_request());
		end
	endtask

	// The receiver stops for a long stretch while moves keep coming, so the result
	// register fills and the block holds off new requests.
	task automatic test_backpressure();
		sweep_req_t r;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		long_hold = 1'b1;
		repeat (8) begin
			r = random_request();
			r.kind = KIND_MOVE;
			send_request(r);
		end
	endtask

	always @(posedge clk) begin
		if (long_hold && stall_count < HOLD_CYCLES) begin
			stall_count <= stall_count + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		sweep_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_moves.size() == 0) begin
				$display("%0t: unexpected result: expected none, got delta %h moved %b",
					$time, m_tdata, m_tuser);
				n_errors++;
			end else begin
				want = expected_moves.pop_front();
				if (m_tdata !== want.delta) begin
					$display("%0t: applied_delta mismatch: expected %h, got %h",
						$time, want.delta, m_tdata);
					n_errors++;
				end
				if (m_tuser !== want.moved) begin
					$display("%0t: moved mismatch: expected %b, got %b",
						$time, want.moved, m_tuser);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_moves.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_OBS; i++) begin
			obs_fixed[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 16;
		rx_idle_pct = 87;
		test_product_rounding();
		test_clamp_x_axis();
		test_clamp_y_axis();
		test_walk_rules();
		test_clamp_saturation();
		test_random_scenes(150, 16, 87);
		test_random_scenes(150, 87, 16);
		test_random_scenes(150, 0, 0);
		test_backpressure();

		s_tvalid <= 1'b0;
		rx_idle_pct = 0;
		while (expected_moves.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d obstacle loads and %0d moves; %0d moves hit an obstacle,",
			n_loads, n_moves, n_clamped);
		$display("%0d ended with no motion, with a long output stall along the way.",
			n_still);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: aabb_sweep_clamp_core.f
rtl/asc_pkg.sv
rtl/asc_head.sv
rtl/asc_cell.sv
rtl/aabb_sweep_clamp_core.sv
dv/aabb_sweep_clamp_core_tb.sv
